/* src/brbpc_pkg.sv */
// Shared types and constants for the byte ring buffer with peek and consume.
package brbpc_pkg;

  // Ring storage depth and the derived pointer and capacity widths.
  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CAP_W = PTR_W + 1;
  localparam int BYTE_W = 8;
  localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // Command codes carried on the input tuser.
  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_CONSUME = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  // Buffer status reported with every result word.
  typedef struct packed {
    logic             full_flag;
    logic             empty_flag;
    logic [PTR_W-1:0] occupancy;
    logic             done_res;
  } status_t;

endpackage

/* src/brbpc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module brbpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/byte_ring_buffer_peek_consume_unit.sv */
// Top level of the byte ring buffer with write, read, peek, consume and clear.
//
//  channel  | signals                      | contents (lowest bit first)
//  ---------+------------------------------+-------------------------------------------
//  command  | s_tvalid s_tready s_tuser    | s_tuser: command
//           | s_tdata                      | s_tdata: write_byte, count, zero fill
//  result   | m_tvalid m_tready m_tdata    | read_byte, done_res, occupancy, empty, full
//  config   | cfg_we cfg_wdata             | capacity (also empties the buffer)
//
// One command word is taken per cycle while no stalled result blocks it; its result appears in the following cycle.
// The result byte comes from the registered read port of the byte memory.
// Pointers update at acceptance, so the next command sees them at once.
// A result held by a stalled sink blocks new commands only while it is not taken.
// Reset empties the buffer and sets the capacity to 1024; the memory is not cleared.
module byte_ring_buffer_peek_consume_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [brbpc_pkg::CAP_W-1:0]   cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // write_byte[7:0], count[17:8], zero
  input  logic [2:0]                    s_tuser,   // command[2:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata    // read_byte, done, occupancy, empty, full
);

  localparam int PW = brbpc_pkg::PTR_W;
  localparam int CW = brbpc_pkg::CAP_W;

  // Architectural state.
  logic [CW-1:0] capacity;
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_next;
  logic [PW-1:0] tail_next;

  // Result stage.
  logic                 res_valid;
  logic                 res_hit;
  brbpc_pkg::status_t   res_status;
  brbpc_pkg::status_t   status_next;
  logic                 hit_next;

  // Decoded command word.
  brbpc_pkg::cmd_t cmd;
  logic [7:0]      write_byte;
  logic [PW-1:0]   count;
  logic            accept;

  // Pointer arithmetic.
  logic [CW-1:0] slots;
  logic [PW-1:0] occ;
  logic [CW-1:0] tail_inc;
  logic [CW-1:0] head_inc;
  logic [PW-1:0] tail_wrap;
  logic [PW-1:0] head_wrap;
  logic [PW-1:0] drop;
  logic [PW-1:0] offset;
  logic [CW-1:0] head_sum;
  logic [PW-1:0] head_off;
  logic          can_write;
  logic          can_read;
  logic          can_peek;
  logic [PW-1:0] occ_next;

  // Memory ports.
  logic          ram_we;
  logic          ram_re;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign cmd        = brbpc_pkg::cmd_t'(s_tuser);
  assign write_byte = s_tdata[7:0];
  assign count      = s_tdata[17:8];
  assign s_tready   = !rst && (!res_valid || m_tready);
  assign accept     = s_tvalid && s_tready;

  // Effective ring size, clamped to the legal range.
  always_comb begin
    if (capacity < brbpc_pkg::CAP_MIN) begin
      slots = brbpc_pkg::CAP_MIN;
    end else if (capacity > brbpc_pkg::CAP_MAX) begin
      slots = brbpc_pkg::CAP_MAX;
    end else begin
      slots = capacity;
    end
  end

  // Occupancy from the two pointers.
  always_comb begin
    if (tail >= head) begin
      occ = tail - head;
    end else begin
      occ = PW'(slots - {1'b0, head} + {1'b0, tail});
    end
  end

  // Single-step wraps; pointers always stay below the ring size.
  assign tail_inc  = {1'b0, tail} + CW'(1);
  assign head_inc  = {1'b0, head} + CW'(1);
  assign tail_wrap = (tail_inc == slots) ? '0 : tail_inc[PW-1:0];
  assign head_wrap = (head_inc == slots) ? '0 : head_inc[PW-1:0];

  // Head plus offset for peek or consume; the sum stays below twice the ring size when used.
  assign drop     = (count < occ) ? count : occ;
  assign offset   = (cmd == brbpc_pkg::CMD_PEEK) ? count : drop;
  assign head_sum = {1'b0, head} + {1'b0, offset};
  assign head_off = (head_sum >= slots) ? PW'(head_sum - slots) : head_sum[PW-1:0];

  assign can_write = {1'b0, occ} < (slots - CW'(1));
  assign can_read  = occ != '0;
  assign can_peek  = count < occ;

  // Command decode: next pointers, status and memory access.
  always_comb begin
    head_next = head;
    tail_next = tail;
    occ_next  = occ;
    hit_next  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head;
    status_next.done_res = 1'b0;
    case (cmd)
      brbpc_pkg::CMD_WRITE: begin
        if (can_write) begin
          tail_next = tail_wrap;
          occ_next  = occ + PW'(1);
          ram_we    = accept;
          status_next.done_res = 1'b1;
        end
      end
      brbpc_pkg::CMD_READ: begin
        if (can_read) begin
          head_next = head_wrap;
          occ_next  = occ - PW'(1);
          hit_next  = 1'b1;
          ram_re    = accept;
          status_next.done_res = 1'b1;
        end
      end
      brbpc_pkg::CMD_PEEK: begin
        if (can_peek) begin
          hit_next  = 1'b1;
          ram_re    = accept;
          ram_raddr = head_off;
          status_next.done_res = 1'b1;
        end
      end
      brbpc_pkg::CMD_CONSUME: begin
        head_next = head_off;
        occ_next  = occ - drop;
        status_next.done_res = 1'b1;
      end
      brbpc_pkg::CMD_CLEAR: begin
        head_next = '0;
        tail_next = '0;
        occ_next  = '0;
        status_next.done_res = 1'b1;
      end
      default: begin
      end
    endcase
    status_next.occupancy  = occ_next;
    status_next.empty_flag = occ_next == '0;
    status_next.full_flag  = {1'b0, occ_next} == (slots - CW'(1));
  end

  // Capacity register and ring pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= brbpc_pkg::CAP_RESET;
      head     <= '0;
      tail     <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
      head     <= '0;
      tail     <= '0;
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  // Result stage; the byte itself comes from the memory read register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_next;
      res_hit    <= hit_next;
    end
  end

  brbpc_ram #(
    .WIDTH (brbpc_pkg::BYTE_W),
    .DEPTH (brbpc_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (write_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign m_tvalid = res_valid;
  assign m_tdata  = {3'b000, res_status, res_hit ? ram_rdata : 8'h00};

endmodule

/* src/brbpc_checker.sv */
// Port-level checks for the byte ring buffer, bound to the top level.
module brbpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A stalled result word holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // The empty flag agrees with a zero occupancy.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[19] == (m_tdata[18:9] == 10'd0)))
    else $error("empty flag disagrees with occupancy");

  // The ring is never both empty and full.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[19] && m_tdata[20]))
    else $error("empty and full at once");

  // A refused command returns a zero byte.
  a_refused: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'h00)
    else $error("refused command returned a byte");

endmodule

bind byte_ring_buffer_peek_consume_unit brbpc_checker u_brbpc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/tb_byte_ring_buffer_peek_consume_unit.sv */
// Testbench for the byte ring buffer with write, read, peek, consume and clear commands.
`timescale 1ns / 1ps

module tb_byte_ring_buffer_peek_consume_unit;

  // One command word as offered on the input stream.
  typedef struct {
    logic [2:0] cmd;
    logic [7:0] wr_byte;
    logic [9:0] count;
  } ring_cmd_t;

  // Buffer status and data returned for one command.
  typedef struct {
    logic [7:0] rd_byte;
    logic       done;
    logic [9:0] occ;
    logic       empty;
    logic       full;
  } ring_reply_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [brbpc_pkg::CAP_W-1:0]   cfg_wdata;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [23:0]                   s_tdata;   // write_byte[7:0], count[17:8], zero fill
  logic [2:0]                    s_tuser;   // command[2:0]
  logic                          m_tvalid;
  logic                          m_tready;
  // read_byte[7:0], done[8], occupancy[18:9], empty[19], full[20]
  logic [23:0]                   m_tdata;

  byte_ring_buffer_peek_consume_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // Stimulus and prediction state.
  ring_cmd_t   pending_cmds[$];
  ring_reply_t predicted_replies[$];
  ring_cmd_t   cmd_on_bus;
  bit          cmd_taken;
  int          err_count;
  int          idle_mode;     // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
  int          hold_left;

  // Shadow copy of the ring.
  logic [7:0]  ring_mem [brbpc_pkg::DEPTH];
  int          ring_head;
  int          ring_tail;
  int          cap_reg;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Effective slot count after clamping the capacity register.
  function automatic int ring_slots();
    int c;
    c = cap_reg;
    if (c < 2) c = 2;
    if (c > brbpc_pkg::DEPTH) c = brbpc_pkg::DEPTH;
    return c;
  endfunction

  function automatic int ring_held(int c);
    if (ring_tail >= ring_head) return ring_tail - ring_head;
    return c - ring_head + ring_tail;
  endfunction

  // Apply one command to the shadow ring and queue the status it should report.
  function automatic void ring_apply(ring_cmd_t it);
    ring_reply_t r;
    int c;
    int occ;
    int drop;
    c = ring_slots();
    occ = ring_held(c);
    r.rd_byte = 8'h00;
    r.done = 1'b0;
    case (it.cmd)
      brbpc_pkg::CMD_WRITE: begin
        if (occ < c - 1) begin
          ring_mem[ring_tail] = it.wr_byte;
          ring_tail = (ring_tail + 1) % c;
          r.done = 1'b1;
        end
      end
      brbpc_pkg::CMD_READ: begin
        if (occ != 0) begin
          r.rd_byte = ring_mem[ring_head];
          ring_head = (ring_head + 1) % c;
          r.done = 1'b1;
        end
      end
      brbpc_pkg::CMD_PEEK: begin
        if (int'(it.count) < occ) begin
          r.rd_byte = ring_mem[(ring_head + int'(it.count)) % c];
          r.done = 1'b1;
        end
      end
      brbpc_pkg::CMD_CONSUME: begin
        drop = (int'(it.count) < occ) ? int'(it.count) : occ;
        ring_head = (ring_head + drop) % c;
        r.done = 1'b1;
      end
      brbpc_pkg::CMD_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
        r.done = 1'b1;
      end
      default: begin
      end
    endcase
    occ = ring_held(c);
    r.occ = occ[9:0];
    r.empty = (ring_head == ring_tail);
    r.full = (((ring_tail + 1) % c) == ring_head);
    predicted_replies.push_back(r);
  endfunction

  function automatic void push_cmd(logic [2:0] cmd, logic [7:0] wb, logic [9:0] cnt);
    ring_cmd_t it;
    it.cmd = cmd;
    it.wr_byte = wb;
    it.count = cnt;
    pending_cmds.push_back(it);
  endfunction

  // Random commands, biased toward filling or draining in alternating runs.
  function automatic void queue_random(int n);
    int r;
    int fill_bias;
    logic [9:0] cnt;
    logic [7:0] wb;
    for (int i = 0; i < n; i++) begin
      fill_bias = ((i / 40) % 2 == 0) ? 70 : 30;
      r = $urandom_range(0, 99);
      wb = 8'($urandom_range(0, 255));
      cnt = ($urandom_range(0, 99) < 65) ? 10'($urandom_range(0, 8))
                                         : 10'($urandom_range(0, 1023));
      if (r < fill_bias) push_cmd(brbpc_pkg::CMD_WRITE, wb, cnt);
      else if (r < fill_bias + (88 - fill_bias) / 2) push_cmd(brbpc_pkg::CMD_READ, wb, cnt);
      else if (r < 88) push_cmd(brbpc_pkg::CMD_PEEK, wb, cnt);
      else if (r < 95) push_cmd(brbpc_pkg::CMD_CONSUME, wb, cnt);
      else if (r < 97) push_cmd(brbpc_pkg::CMD_CLEAR, wb, cnt);
      else push_cmd(3'($urandom_range(5, 7)), wb, cnt);
    end
  endfunction

  // Record accepted command words and capacity writes at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        cap_reg = int'(cfg_wdata);
        ring_head = 0;
        ring_tail = 0;
      end
      if (s_tvalid && s_tready) begin
        ring_apply(cmd_on_bus);
        cmd_taken = 1'b1;
      end
    end
  end

  // Driver: offer the next command word at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || cmd_taken) begin
      cmd_taken = 1'b0;
      if (pending_cmds.size() != 0 &&
          !((idle_mode == 1 && $urandom_range(0, 99) < 59) ||
            (idle_mode == 3 && $urandom_range(0, 99) < 29))) begin
        cmd_on_bus = pending_cmds.pop_front();
        s_tuser <= cmd_on_bus.cmd;
        s_tdata <= {6'b0, cmd_on_bus.count, cmd_on_bus.wr_byte};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready, with random stalls and a single long hold-off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (idle_mode == 2) begin
      m_tready <= ($urandom_range(0, 99) >= 59);
    end else if (idle_mode == 3) begin
      m_tready <= ($urandom_range(0, 99) >= 29);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    ring_reply_t want;
    ring_reply_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.rd_byte = m_tdata[7:0];
      got.done = m_tdata[8];
      got.occ = m_tdata[18:9];
      got.empty = m_tdata[19];
      got.full = m_tdata[20];
      if (predicted_replies.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, m_tdata);
        err_count++;
      end else begin
        want = predicted_replies.pop_front();
        if (got.rd_byte !== want.rd_byte) begin
          $display("%0t: read_byte expected %h got %h", $time, want.rd_byte, got.rd_byte);
          err_count++;
        end
        if (got.done !== want.done) begin
          $display("%0t: done expected %b got %b", $time, want.done, got.done);
          err_count++;
        end
        if (got.occ !== want.occ) begin
          $display("%0t: occupancy expected %0d got %0d", $time, want.occ, got.occ);
          err_count++;
        end
        if (got.empty !== want.empty) begin
          $display("%0t: empty expected %b got %b", $time, want.empty, got.empty);
          err_count++;
        end
        if (got.full !== want.full) begin
          $display("%0t: full expected %b got %b", $time, want.full, got.full);
          err_count++;
        end
      end
    end
  end

  // Wait until every queued word is taken and every result has come back.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || s_tvalid || predicted_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [brbpc_pkg::CAP_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main sequence: reset, directed checks, then phases over several capacities.
  initial begin
    logic [brbpc_pkg::CAP_W-1:0] caps [9];
    int                          modes [9];
    int                          counts [9];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cmd_taken = 1'b0;
    err_count = 0;
    idle_mode = 0;
    hold_left = 0;
    ring_head = 0;
    ring_tail = 0;
    cap_reg = int'(brbpc_pkg::CAP_RESET);
    caps = '{11'd0, 11'd1, 11'd5, 11'd17, 11'd2047, 11'd1024, 11'd3,
             11'($urandom_range(2, 64)), 11'($urandom_range(0, 2047))};
    modes = '{2, 3, 0, 1, 2, 3, 2, 1, 3};
    counts = '{50, 30, 110, 120, 60, 40, 80, 100, 80};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset capacity: empty reads, peeks, extremes.
    push_cmd(brbpc_pkg::CMD_READ, 8'h00, 10'd0);
    push_cmd(brbpc_pkg::CMD_PEEK, 8'h00, 10'd0);
    push_cmd(brbpc_pkg::CMD_WRITE, 8'h00, 10'd0);
    push_cmd(brbpc_pkg::CMD_WRITE, 8'hFF, 10'h3FF);
    push_cmd(brbpc_pkg::CMD_WRITE, 8'hA5, 10'h155);
    push_cmd(brbpc_pkg::CMD_PEEK, 8'h00, 10'd0);
    push_cmd(brbpc_pkg::CMD_PEEK, 8'h00, 10'd2);
    push_cmd(brbpc_pkg::CMD_PEEK, 8'h00, 10'd3);
    push_cmd(brbpc_pkg::CMD_PEEK, 8'hFF, 10'h3FF);
    push_cmd(brbpc_pkg::CMD_READ, 8'h00, 10'd0);
    push_cmd(brbpc_pkg::CMD_CONSUME, 8'h00, 10'd0);
    push_cmd(brbpc_pkg::CMD_CONSUME, 8'h00, 10'h3FF);
    push_cmd(brbpc_pkg::CMD_READ, 8'h00, 10'd0);
    push_cmd(3'd5, 8'h12, 10'd1);
    push_cmd(3'd6, 8'h34, 10'd2);
    push_cmd(3'd7, 8'h56, 10'd3);
    push_cmd(brbpc_pkg::CMD_WRITE, 8'h3C, 10'd0);
    push_cmd(brbpc_pkg::CMD_CLEAR, 8'h00, 10'd0);
    queue_random(60);
    wait_drained();

    // Two slots: a single byte fills the ring.
    write_capacity(11'd2);
    idle_mode = 1;
    push_cmd(brbpc_pkg::CMD_WRITE, 8'h81, 10'd0);
    push_cmd(brbpc_pkg::CMD_WRITE, 8'h7E, 10'd0);
    push_cmd(brbpc_pkg::CMD_PEEK, 8'h00, 10'd0);
    push_cmd(brbpc_pkg::CMD_PEEK, 8'h00, 10'd1);
    push_cmd(brbpc_pkg::CMD_READ, 8'h00, 10'd0);
    push_cmd(brbpc_pkg::CMD_READ, 8'h00, 10'd0);
    queue_random(80);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      write_capacity(caps[p]);
      idle_mode = modes[p];
      queue_random(counts[p]);
      // Long receiver hold-off while the sender keeps offering words.
      if (p == 2) begin
        @(posedge clk);
        hold_left = 300;
      end
      wait_drained();
    end

    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_byte_ring_buffer_peek_consume_unit: PASS");
    end else begin
      $display("tb_byte_ring_buffer_peek_consume_unit: FAIL");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #3600000;
    $display("tb_byte_ring_buffer_peek_consume_unit: FAIL");
    $finish;
  end

endmodule

/* sim.f */
src/brbpc_pkg.sv
src/brbpc_ram.sv
src/byte_ring_buffer_peek_consume_unit.sv
src/brbpc_checker.sv
tb/tb_byte_ring_buffer_peek_consume_unit.sv
